// ===== rtl/p2ld_pkg.sv =====
// ----------------------------------------------------------------------------
// p2ld_pkg
// Shared constants and types for the 3D point-to-line distance pipeline.
// ----------------------------------------------------------------------------
package p2ld_pkg;

	localparam int STATUS_WIDTH = 2;
	localparam int EPS_WIDTH    = 64;

	typedef logic [STATUS_WIDTH-1:0] status_t;
	typedef logic [EPS_WIDTH-1:0]    eps_t;

	// Result status codes
	localparam status_t ST_NORMAL    = 2'd0;
	localparam status_t ST_POINT_ORG = 2'd1;
	localparam status_t ST_DIR_ZERO  = 2'd2;

	localparam eps_t EPS_RESET = 64'd4295;

endpackage

// ===== rtl/p2ld_if.sv =====
// ----------------------------------------------------------------------------
// p2ld channel interfaces
// Valid/ready channels for requests, results and the epsilon register write.
// ----------------------------------------------------------------------------
interface p2ld_req_if #(parameter int W = 32);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] point_x;
	logic signed [W-1:0] point_y;
	logic signed [W-1:0] point_z;
	logic signed [W-1:0] origin_x;
	logic signed [W-1:0] origin_y;
	logic signed [W-1:0] origin_z;
	logic signed [W-1:0] dir_x;
	logic signed [W-1:0] dir_y;
	logic signed [W-1:0] dir_z;

	modport source (output valid, point_x, point_y, point_z, origin_x, origin_y, origin_z,
		dir_x, dir_y, dir_z, input ready);
	modport sink (input valid, point_x, point_y, point_z, origin_x, origin_y, origin_z,
		dir_x, dir_y, dir_z, output ready);
endinterface

interface p2ld_rsp_if #(parameter int W = 32);
	logic         valid;
	logic         ready;
	logic [W+1:0] distance;
	logic [1:0]   status;

	modport source (output valid, distance, status, input ready);
	modport sink (input valid, distance, status, output ready);
endinterface

interface p2ld_cfg_if;
	logic        valid;
	logic        ready;
	logic [63:0] epsilon_squared;

	modport source (output valid, epsilon_squared, input ready);
	modport sink (input valid, epsilon_squared, output ready);
endinterface

// ===== rtl/point_to_line_distance_3d.sv =====
// ----------------------------------------------------------------------------
// point_to_line_distance_3d
// Fully pipelined distance from a point to a line in 3D, signed fixed point.
// ----------------------------------------------------------------------------
// Accepts one request per clock while no result is stalled, and returns one
// result per request, in order. The pipeline is seven arithmetic stages
// (difference, products, cross terms, magnitude and threshold checks, split
// squares, square sums, total), then a restoring divider that retires one
// quotient bit per stage over 2*(COORD_WIDTH+2) stages, then a square root
// that retires one result bit per stage over COORD_WIDTH+2 stages. A stalled
// result holds the whole pipeline; requests are taken whenever the result
// register is empty or being drained.
// Distance is floor(|R x D| / |D|); degenerate inputs give zero and a status.
module point_to_line_distance_3d #(
	parameter int COORD_WIDTH = 32
) (
	input logic       clk,
	input logic       arst_n,
	p2ld_cfg_if.sink  cfg,
	p2ld_req_if.sink  req,
	p2ld_rsp_if.source rsp
);
	import p2ld_pkg::*;

	localparam int CW   = COORD_WIDTH;
	localparam int PW   = 2*CW + 1;          // cross product term
	localparam int CDW  = 2*CW + 2;          // cross component, signed
	localparam int MW   = 2*CW + 1;          // cross component magnitude
	localparam int LO   = MW / 2;
	localparam int HI   = MW - LO;
	localparam int R2W  = 2*CW + 3;
	localparam int D2W  = 2*CW + 1;
	localparam int C2W  = 4*CW + 3;
	localparam int DW   = CW + 2;            // distance width
	localparam int QW   = 2*DW;              // quotient width
	localparam int CMPW = (R2W > EPS_WIDTH) ? R2W : EPS_WIDTH;

	logic en;
	eps_t eps_q;

	// Epsilon register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg.valid) begin
			eps_q <= cfg.epsilon_squared;
		end
	end

	// Advance the pipeline unless the result register holds a stalled result
	assign en        = !rsp.valid || rsp.ready;
	assign req.ready = en;

	// Valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic dv_v [1:QW];
	logic sr_v [1:DW];

	// Stage 1: R = P - O
	logic signed [CW:0]   rx_s1, ry_s1, rz_s1;
	logic signed [CW-1:0] dx_s1, dy_s1, dz_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			rx_s1 <= $signed({req.point_x[CW-1], req.point_x})
				- $signed({req.origin_x[CW-1], req.origin_x});
			ry_s1 <= $signed({req.point_y[CW-1], req.point_y})
				- $signed({req.origin_y[CW-1], req.origin_y});
			rz_s1 <= $signed({req.point_z[CW-1], req.point_z})
				- $signed({req.origin_z[CW-1], req.origin_z});
			dx_s1 <= req.dir_x;
			dy_s1 <= req.dir_y;
			dz_s1 <= req.dir_z;
		end
	end

	// Stage 2: cross terms and squares
	logic signed [PW-1:0]   p_yz_s2, p_zy_s2, p_zx_s2, p_xz_s2, p_xy_s2, p_yx_s2;
	logic signed [2*CW+1:0] rxx_s2, ryy_s2, rzz_s2;
	logic signed [2*CW-1:0] dxx_s2, dyy_s2, dzz_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			p_yz_s2 <= ry_s1 * dz_s1;
			p_zy_s2 <= rz_s1 * dy_s1;
			p_zx_s2 <= rz_s1 * dx_s1;
			p_xz_s2 <= rx_s1 * dz_s1;
			p_xy_s2 <= rx_s1 * dy_s1;
			p_yx_s2 <= ry_s1 * dx_s1;
			rxx_s2  <= rx_s1 * rx_s1;
			ryy_s2  <= ry_s1 * ry_s1;
			rzz_s2  <= rz_s1 * rz_s1;
			dxx_s2  <= dx_s1 * dx_s1;
			dyy_s2  <= dy_s1 * dy_s1;
			dzz_s2  <= dz_s1 * dz_s1;
		end
	end

	// Stage 3: cross components and squared lengths
	logic signed [CDW-1:0] cx_s3, cy_s3, cz_s3;
	logic [R2W-1:0]        r2_s3;
	logic [D2W-1:0]        d2_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s3 <= CDW'(p_yz_s2) - CDW'(p_zy_s2);
			cy_s3 <= CDW'(p_zx_s2) - CDW'(p_xz_s2);
			cz_s3 <= CDW'(p_xy_s2) - CDW'(p_yx_s2);
			r2_s3 <= R2W'(rxx_s2[2*CW:0]) + R2W'(ryy_s2[2*CW:0]) + R2W'(rzz_s2[2*CW:0]);
			d2_s3 <= D2W'(dxx_s2[2*CW-2:0]) + D2W'(dyy_s2[2*CW-2:0])
				+ D2W'(dzz_s2[2*CW-2:0]);
		end
	end

	// Stage 4: magnitudes and degenerate checks
	logic [CDW-1:0]  ncx, ncy, ncz;
	logic [CMPW-1:0] r2_ext, d2_ext, eps_ext;
	status_t         st_next;
	assign ncx     = -cx_s3;
	assign ncy     = -cy_s3;
	assign ncz     = -cz_s3;
	assign r2_ext  = CMPW'(r2_s3);
	assign d2_ext  = CMPW'(d2_s3);
	assign eps_ext = CMPW'(eps_q);
	always_comb begin
		if (r2_ext < eps_ext) begin
			st_next = ST_POINT_ORG;
		end else if (d2_ext < eps_ext || d2_s3 == '0) begin
			st_next = ST_DIR_ZERO;
		end else begin
			st_next = ST_NORMAL;
		end
	end

	logic [MW-1:0]  mx_s4, my_s4, mz_s4;
	logic [D2W-1:0] d2_s4;
	status_t        st_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			mx_s4 <= cx_s3[CDW-1] ? ncx[MW-1:0] : cx_s3[MW-1:0];
			my_s4 <= cy_s3[CDW-1] ? ncy[MW-1:0] : cy_s3[MW-1:0];
			mz_s4 <= cz_s3[CDW-1] ? ncz[MW-1:0] : cz_s3[MW-1:0];
			d2_s4 <= d2_s3;
			st_s4 <= st_next;
		end
	end

	// Stage 5: split squares of the cross components
	logic [2*HI-1:0]  hh_s5 [0:2];
	logic [HI+LO-1:0] hl_s5 [0:2];
	logic [2*LO-1:0]  ll_s5 [0:2];
	logic [MW-1:0]    m_s4 [0:2];
	logic [D2W-1:0]   d2_s5;
	status_t          st_s5;
	assign m_s4[0] = mx_s4;
	assign m_s4[1] = my_s4;
	assign m_s4[2] = mz_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				hh_s5[k] <= m_s4[k][MW-1:LO] * m_s4[k][MW-1:LO];
				hl_s5[k] <= m_s4[k][MW-1:LO] * m_s4[k][LO-1:0];
				ll_s5[k] <= m_s4[k][LO-1:0] * m_s4[k][LO-1:0];
			end
			d2_s5 <= d2_s4;
			st_s5 <= st_s4;
		end
	end

	// Stage 6: assemble each square
	logic [C2W-1:0] sq_s6 [0:2];
	logic [D2W-1:0] d2_s6;
	status_t        st_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sq_s6[k] <= (C2W'(hh_s5[k]) << (2*LO)) + (C2W'(hl_s5[k]) << (LO+1))
					+ C2W'(ll_s5[k]);
			end
			d2_s6 <= d2_s5;
			st_s6 <= st_s5;
		end
	end

	// Stage 7: |C|^2
	logic [C2W-1:0] c2_s7;
	logic [D2W-1:0] d2_s7;
	status_t        st_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			c2_s7 <= sq_s6[0] + sq_s6[1] + sq_s6[2];
			d2_s7 <= d2_s6;
			st_s7 <= st_s6;
		end
	end

	// Front valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Divider: Q = floor(|C|^2 / |D|^2), one quotient bit per stage
	logic [D2W-1:0] dv_rem_s [0:QW];
	logic [QW-1:0]  dv_num_s [0:QW];
	logic [D2W-1:0] dv_d2_s  [0:QW];
	status_t        dv_st_s  [0:QW];

	assign dv_rem_s[0] = D2W'(c2_s7[C2W-1:QW]);
	assign dv_num_s[0] = c2_s7[QW-1:0];
	assign dv_d2_s[0]  = d2_s7;
	assign dv_st_s[0]  = st_s7;

	for (genvar i = 0; i < QW; i++) begin : g_div
		logic [D2W:0] trial;
		logic         ge;
		logic [D2W:0] diff;
		assign trial = {dv_rem_s[i], dv_num_s[i][QW-1]};
		assign ge    = trial >= {1'b0, dv_d2_s[i]};
		assign diff  = trial - {1'b0, dv_d2_s[i]};

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s[i+1] <= ge ? diff[D2W-1:0] : trial[D2W-1:0];
				dv_num_s[i+1] <= {dv_num_s[i][QW-2:0], ge};
				dv_d2_s[i+1]  <= dv_d2_s[i];
				dv_st_s[i+1]  <= dv_st_s[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[i+1] <= 1'b0;
			end else if (en) begin
				dv_v[i+1] <= (i == 0) ? v_s7 : dv_v[(i == 0) ? 1 : i];
			end
		end
	end

	// Square root of Q, one result bit per stage
	logic [QW-1:0] sr_rem_s [0:DW];
	logic [DW-1:0] sr_q_s   [0:DW];
	status_t       sr_st_s  [0:DW];

	assign sr_rem_s[0] = dv_num_s[QW];
	assign sr_q_s[0]   = '0;
	assign sr_st_s[0]  = dv_st_s[QW];

	for (genvar k = 0; k < DW; k++) begin : g_sqrt
		localparam int B = DW - 1 - k;
		logic [QW-1:0] trial;
		logic          ge;
		assign trial = (QW'(sr_q_s[k]) << (B+1)) | (QW'(1) << (2*B));
		assign ge    = sr_rem_s[k] >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				sr_rem_s[k+1] <= ge ? (sr_rem_s[k] - trial) : sr_rem_s[k];
				sr_q_s[k+1]   <= sr_q_s[k] | (ge ? (DW'(1) << B) : '0);
				sr_st_s[k+1]  <= sr_st_s[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sr_v[k+1] <= 1'b0;
			end else if (en) begin
				sr_v[k+1] <= (k == 0) ? dv_v[QW] : sr_v[(k == 0) ? 1 : k];
			end
		end
	end

	// Drive the result from the last stage
	assign rsp.valid    = sr_v[DW];
	assign rsp.status   = sr_st_s[DW];
	assign rsp.distance = (sr_st_s[DW] == ST_NORMAL) ? sr_q_s[DW] : '0;

endmodule

// ===== rtl/p2ld_checker.sv =====
// ----------------------------------------------------------------------------
// p2ld_props
// Port-level checks on the distance pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module p2ld_props #(
	parameter int W = 32
) (
	input logic         clk,
	input logic         arst_n,
	input logic         in_ready,
	input logic         out_valid,
	input logic         out_ready,
	input logic [W+1:0] distance,
	input logic [1:0]   status
);
	import p2ld_pkg::*;

	// Hold a stalled result unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(status))
		else $error("result changed while stalled");

	// Degenerate results carry zero distance
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_NORMAL |-> distance == '0)
		else $error("nonzero distance on degenerate result");

	// Back-pressure to requests comes only from a stalled result
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("request stalled without a stalled result");

endmodule

bind point_to_line_distance_3d p2ld_props #(.W(COORD_WIDTH)) u_p2ld_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.distance  (rsp.distance),
	.status    (rsp.status)
);
